FILE: hdl/adam_pkg.sv
// adam_pkg: shared widths, register codes, reset values and tag types
// for the adam optimizer update block; no dependencies
package adam_pkg;

    localparam int ELEMENT_COUNT_DEF = 65536;
    localparam int INDEX_W           = 16;
    localparam int DATA_W            = 32;
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DECAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DECAY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STABILITY_TERM = 2'd3;

    localparam logic [DATA_W-1:0] LEARNING_RATE_RST  = 32'd4294967;
    localparam logic [DATA_W-1:0] FIRST_DECAY_RST    = 32'd3865470566;
    localparam logic [DATA_W-1:0] SECOND_DECAY_RST   = 32'd4290672329;
    localparam logic [DATA_W-1:0] STABILITY_TERM_RST = 32'd43;

    localparam logic [DATA_W-1:0] Q32_ONE_SAT = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] POS_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_MAX     = 32'h8000_0000;
    localparam logic [DATA_W:0]   Q32_ONE     = 33'h1_0000_0000;

    // bias correction dividers: (|x| << 32 + den/2) / den, 33 quotient bits
    localparam int BC_NUM_W  = 65;
    localparam int BC_DEN_W  = 33;
    localparam int BC_QUOT_W = 33;

    // root of vhat * 2^32, widened by 8 bits, plus epsilon
    localparam int ROOT_W     = 32;
    localparam int ROOT_SHIFT = 8;
    localparam int DD_W       = 41;

    // final divider: (eta * |mhat| + dd/2) / dd
    localparam int FD_NUM_W  = 64;
    localparam int FD_QUOT_W = 32;

    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [DATA_W-1:0] mhat;
    } root_tag_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic mzero;
    } final_tag_t;

endpackage

FILE: hdl/adam_grad_if.sv
// adam_grad_if: gradient request channel, valid/ready with payload
// depends on adam_pkg
interface adam_grad_if import adam_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [INDEX_W-1:0]        element_index;
    logic signed [DATA_W-1:0]  gradient;
    logic                      first_of_tensor;
    logic                      fresh;

    modport source (output valid, element_index, gradient, first_of_tensor, fresh,
                    input ready);
    modport sink (input valid, element_index, gradient, first_of_tensor, fresh,
                  output ready);
endinterface

FILE: hdl/adam_delta_if.sv
// adam_delta_if: weight delta result channel, valid/ready with payload
// depends on adam_pkg
interface adam_delta_if import adam_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  weight_delta;

    modport source (output valid, weight_delta, input ready);
    modport sink (input valid, weight_delta, output ready);
endinterface

FILE: hdl/adam_cfg_if.sv
// adam_cfg_if: configuration write channel, register index and data
// depends on adam_pkg
interface adam_cfg_if import adam_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/adam_div_pipe.sv
// adam_div_pipe: pipelined restoring divider, one quotient bit per stage,
// with overflow flag and a tag that travels with the data; no dependencies
module adam_div_pipe #(
    parameter int NW = 65,
    parameter int DW = 33,
    parameter int QB = 33,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag_in,
    output logic [QB-1:0] quot,
    output logic          sat,
    output logic [TW-1:0] tag_out
);

    localparam int HW = NW - QB;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [DW-1:0] rem_reg  [0:QB];
    logic [QB-1:0] work_reg [0:QB];
    logic [DW-1:0] den_reg  [0:QB];
    logic          sat_reg  [0:QB];
    logic [TW-1:0] tag_reg  [0:QB];

    logic [HW-1:0] hi;
    logic          ovf;

    assign hi  = num[NW-1:QB];
    assign ovf = CW'(hi) >= CW'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DW'(hi);
            work_reg[0] <= num[QB-1:0];
            den_reg[0]  <= den;
            sat_reg[0]  <= ovf;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        logic [DW:0]   remp;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QB-1:0] work_next;

        assign remp      = {rem_reg[k-1], work_reg[k-1][QB-1]};
        assign diff      = remp - {1'b0, den_reg[k-1]};
        assign ge        = remp >= {1'b0, den_reg[k-1]};
        assign rem_next  = ge ? diff[DW-1:0] : remp[DW-1:0];
        assign work_next = {work_reg[k-1][QB-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else if (en)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                work_reg[k] <= work_next;
                den_reg[k]  <= den_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
            end
        end
    end

    assign quot    = work_reg[QB];
    assign sat     = sat_reg[QB];
    assign tag_out = tag_reg[QB];

endmodule

FILE: hdl/adam_sqrt_pipe.sv
// adam_sqrt_pipe: pipelined digit-by-digit integer root of x * 2^QW,
// one root bit per stage, tag travels with the data; no dependencies
module adam_sqrt_pipe #(
    parameter int QW = 32,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [QW-1:0] x,
    input  logic [TW-1:0] tag_in,
    output logic [QW-1:0] root,
    output logic [TW-1:0] tag_out
);

    localparam int RW = QW + 2;

    logic [RW-1:0] rem_reg  [0:QW-1];
    logic [QW-1:0] root_reg [0:QW-1];
    logic [QW-1:0] xs_reg   [0:QW-1];
    logic [TW-1:0] tag_reg  [0:QW-1];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [RW-1:0] rem_in;
        logic [QW-1:0] root_in;
        logic [QW-1:0] xs_in;
        logic [TW-1:0] tag_src;
        logic [RW+1:0] remp;
        logic [RW+1:0] trial;
        logic [RW+1:0] diff;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign xs_in   = x;
            assign tag_src = tag_in;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign xs_in   = xs_reg[i-1];
            assign tag_src = tag_reg[i-1];
        end

        assign remp  = {rem_in, xs_in[QW-1:QW-2]};
        assign trial = (RW+2)'({root_in, 2'b01});
        assign diff  = remp - trial;
        assign ge    = remp >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[i] <= '0;
            end
            else if (en)
            begin
                tag_reg[i] <= tag_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? diff[RW-1:0] : remp[RW-1:0];
                root_reg[i] <= {root_in[QW-2:0], ge};
                xs_reg[i]   <= {xs_in[QW-3:0], 2'b00};
            end
        end
    end

    assign root    = root_reg[QW-1];
    assign tag_out = tag_reg[QW-1];

endmodule

FILE: hdl/adam_optimizer_update.sv
// adam_optimizer_update: one request per cycle while the skid entry is empty, set by the
// bit-per-stage dividers and root pipeline; a two-entry output (register plus skid) decouples
// the result side from the pipeline; reset clears all valid bits, restores register defaults
// and sets both decay powers to one; moment memories are not cleared, and the user must see
// that they are read only after a fresh write; the block itself does not enforce it
// depends on adam_pkg, adam_grad_if, adam_delta_if, adam_cfg_if, adam_div_pipe, adam_sqrt_pipe
module adam_optimizer_update import adam_pkg::*; #(
    parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    adam_grad_if.sink  grad,
    adam_delta_if.source delta,
    adam_cfg_if.sink   cfg
);

    localparam int AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / ELEMENT_COUNT);
    localparam logic [40:0] COUNT41 = 41'(ELEMENT_COUNT);
    localparam logic [65:0] RND66 = 66'h8000_0000;
    localparam logic [63:0] RND64 = 64'h8000_0000;

    // configuration
    logic [DATA_W-1:0] learning_rate_reg;
    logic [DATA_W-1:0] first_decay_reg;
    logic [DATA_W-1:0] second_decay_reg;
    logic [DATA_W-1:0] stability_term_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg  <= LEARNING_RATE_RST;
            first_decay_reg    <= FIRST_DECAY_RST;
            second_decay_reg   <= SECOND_DECAY_RST;
            stability_term_reg <= STABILITY_TERM_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_LEARNING_RATE:  learning_rate_reg  <= cfg.data;
                CFG_FIRST_DECAY:    first_decay_reg    <= cfg.data;
                CFG_SECOND_DECAY:   second_decay_reg   <= cfg.data;
                CFG_STABILITY_TERM: stability_term_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline enable and request acceptance
    logic en;
    logic accept;
    logic skid_valid_reg;

    assign en         = !skid_valid_reg;
    assign grad.ready = en;
    assign accept     = grad.valid && en;

    // running decay powers
    logic [DATA_W-1:0] p1_reg, p2_reg;
    logic [DATA_W-1:0] p1_src, p2_src;
    logic [63:0]       p1_sum, p2_sum;
    logic [DATA_W-1:0] p1_item, p2_item;
    logic              restart;

    assign restart = grad.first_of_tensor && grad.fresh;
    assign p1_src  = restart ? Q32_ONE_SAT : p1_reg;
    assign p2_src  = restart ? Q32_ONE_SAT : p2_reg;
    assign p1_sum  = 64'(p1_src) * 64'(first_decay_reg) + RND64;
    assign p2_sum  = 64'(p2_src) * 64'(second_decay_reg) + RND64;
    assign p1_item = grad.first_of_tensor ? p1_sum[63:32] : p1_reg;
    assign p2_item = grad.first_of_tensor ? p2_sum[63:32] : p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= Q32_ONE_SAT;
            p2_reg <= Q32_ONE_SAT;
        end
        else if (accept)
        begin
            p1_reg <= p1_item;
            p2_reg <= p2_item;
        end
    end

    // address wrap quotient estimate
    logic [47:0] idx_prod;
    assign idx_prod = 48'(grad.element_index) * 48'(RECIP);

    // stage 1
    logic                     s1_valid_reg;
    logic [INDEX_W-1:0]       s1_idx_reg;
    logic [INDEX_W-1:0]       s1_quot_reg;
    logic signed [DATA_W-1:0] s1_grad_reg;
    logic                     s1_fresh_reg;
    logic [DATA_W-1:0]        s1_p1_reg, s1_p2_reg;

    // stage 2
    logic                     s2_valid_reg;
    logic [AW-1:0]            s2_addr_reg;
    logic signed [DATA_W-1:0] s2_grad_reg;
    logic [DATA_W-1:0]        s2_g2_reg;
    logic                     s2_fresh_reg;
    logic [DATA_W-1:0]        s2_p1_reg, s2_p2_reg;

    // stage 3
    logic                     s3_valid_reg;
    logic [AW-1:0]            s3_addr_reg;
    logic                     s3_fresh_reg;
    logic signed [65:0]       s3_gterm_m_reg;
    logic [63:0]              s3_gterm_v_reg;
    logic [DATA_W-1:0]        s3_p1_reg, s3_p2_reg;
    logic signed [DATA_W-1:0] rd_m_reg;
    logic [DATA_W-1:0]        rd_v_reg;

    // stage 4
    logic                     s4_valid_reg;
    logic [AW-1:0]            s4_addr_reg;
    logic signed [DATA_W-1:0] s4_m_reg;
    logic [DATA_W-1:0]        s4_v_reg;
    logic [DATA_W-1:0]        s4_p1_reg, s4_p2_reg;

    // stage 1 logic: address wrap and gradient square
    logic [40:0]       quot_scaled, rem_raw, rem_fix;
    logic [AW-1:0]     s1_addr;
    logic [DATA_W-1:0] gmag;
    logic [63:0]       gsq;
    logic [DATA_W-1:0] g2;

    assign quot_scaled = 41'(s1_quot_reg) * COUNT41;
    assign rem_raw     = 41'(s1_idx_reg) - quot_scaled;
    assign rem_fix     = (rem_raw >= COUNT41) ? rem_raw - COUNT41 : rem_raw;
    assign s1_addr     = rem_fix[AW-1:0];
    assign gmag        = s1_grad_reg[DATA_W-1] ? 32'(-s1_grad_reg) : 32'(s1_grad_reg);
    assign gsq         = 64'(gmag) * 64'(gmag) + 64'd32768;
    assign g2          = (|gsq[63:48]) ? Q32_ONE_SAT : gsq[47:16];

    // stage 2 logic: gradient terms
    logic [DATA_W:0]    om1, om2;
    logic signed [65:0] gterm_m;
    logic [63:0]        gterm_v;

    assign om1     = Q32_ONE - 33'(first_decay_reg);
    assign om2     = Q32_ONE - 33'(second_decay_reg);
    assign gterm_m = 66'(s2_grad_reg) * 66'($signed({1'b0, om1}));
    assign gterm_v = 64'(s2_g2_reg) * 64'(om2);

    // stage 3 logic: moment update with forwarding from the previous item
    logic                     fwd;
    logic signed [DATA_W-1:0] m_old;
    logic [DATA_W-1:0]        v_old;
    logic signed [65:0]       m_prod;
    logic [65:0]              m_sum, v_sum;
    logic [33:0]              m_rnd, v_rnd;
    logic signed [DATA_W-1:0] m_next;
    logic [DATA_W-1:0]        v_next;
    logic                     m_fits;

    assign fwd    = s4_valid_reg && (s4_addr_reg == s3_addr_reg);
    assign m_old  = s3_fresh_reg ? '0 : (fwd ? s4_m_reg : rd_m_reg);
    assign v_old  = s3_fresh_reg ? '0 : (fwd ? s4_v_reg : rd_v_reg);
    assign m_prod = 66'(m_old) * 66'($signed({1'b0, first_decay_reg}));
    assign m_sum  = m_prod + s3_gterm_m_reg + RND66;
    assign m_rnd  = m_sum[65:32];
    assign m_fits = (m_rnd[33:31] == 3'b000) || (m_rnd[33:31] == 3'b111);
    assign m_next = m_fits ? m_rnd[31:0] : (m_rnd[33] ? NEG_MAX : POS_MAX);
    assign v_sum  = 66'(64'(v_old) * 64'(second_decay_reg)) + 66'(s3_gterm_v_reg) + RND66;
    assign v_rnd  = v_sum[65:32];
    assign v_next = (|v_rnd[33:32]) ? Q32_ONE_SAT : v_rnd[31:0];

    // moment memories
    logic [DATA_W-1:0] first_mem  [0:ELEMENT_COUNT-1];
    logic [DATA_W-1:0] second_mem [0:ELEMENT_COUNT-1];

    always_ff @(posedge clk)
    begin
        if (en && s3_valid_reg)
        begin
            first_mem[s3_addr_reg]  <= m_next;
            second_mem[s3_addr_reg] <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_m_reg <= first_mem[s2_addr_reg];
            rd_v_reg <= second_mem[s2_addr_reg];
        end
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= grad.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg     <= grad.element_index;
            s1_quot_reg    <= idx_prod[47:32];
            s1_grad_reg    <= grad.gradient;
            s1_fresh_reg   <= grad.fresh;
            s1_p1_reg      <= p1_item;
            s1_p2_reg      <= p2_item;

            s2_addr_reg    <= s1_addr;
            s2_grad_reg    <= s1_grad_reg;
            s2_g2_reg      <= g2;
            s2_fresh_reg   <= s1_fresh_reg;
            s2_p1_reg      <= s1_p1_reg;
            s2_p2_reg      <= s1_p2_reg;

            s3_addr_reg    <= s2_addr_reg;
            s3_fresh_reg   <= s2_fresh_reg;
            s3_gterm_m_reg <= gterm_m;
            s3_gterm_v_reg <= gterm_v;
            s3_p1_reg      <= s2_p1_reg;
            s3_p2_reg      <= s2_p2_reg;

            s4_addr_reg    <= s3_addr_reg;
            s4_m_reg       <= m_next;
            s4_v_reg       <= v_next;
            s4_p1_reg      <= s3_p1_reg;
            s4_p2_reg      <= s3_p2_reg;
        end
    end

    // bias correction
    logic              m_neg;
    logic [DATA_W-1:0] m_abs;
    logic [DATA_W:0]   den1, den2;
    logic [64:0]       num1, num2;

    assign m_neg = s4_m_reg[DATA_W-1];
    assign m_abs = m_neg ? 32'(-s4_m_reg) : 32'(s4_m_reg);
    assign den1  = Q32_ONE - 33'(s4_p1_reg);
    assign den2  = Q32_ONE - 33'(s4_p2_reg);
    assign num1  = {1'b0, m_abs, 32'b0} + 65'(den1 >> 1);
    assign num2  = {1'b0, s4_v_reg, 32'b0} + 65'(den2 >> 1);

    logic [BC_QUOT_W-1:0] q1, q2;
    logic                 sat1, sat2;
    logic                 d1_valid, d2_neg;

    adam_div_pipe #(
        .NW (BC_NUM_W),
        .DW (BC_DEN_W),
        .QB (BC_QUOT_W),
        .TW (1)
    ) u_div_mhat (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (num1),
        .den     (den1),
        .tag_in  (s4_valid_reg),
        .quot    (q1),
        .sat     (sat1),
        .tag_out (d1_valid)
    );

    adam_div_pipe #(
        .NW (BC_NUM_W),
        .DW (BC_DEN_W),
        .QB (BC_QUOT_W),
        .TW (1)
    ) u_div_vhat (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (num2),
        .den     (den2),
        .tag_in  (m_neg),
        .quot    (q2),
        .sat     (sat2),
        .tag_out (d2_neg)
    );

    // stage 5: saturate corrected moments
    logic              s5_valid_reg;
    logic              s5_neg_reg;
    logic [DATA_W-1:0] s5_mhat_reg;
    logic [DATA_W-1:0] s5_vhat_reg;
    logic [DATA_W-1:0] cap1;
    logic [DATA_W-1:0] mhat_next, vhat_next;

    assign cap1      = d2_neg ? NEG_MAX : POS_MAX;
    assign mhat_next = (sat1 || (q1 > 33'(cap1))) ? cap1 : q1[31:0];
    assign vhat_next = (sat2 || q2[32]) ? Q32_ONE_SAT : q2[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_neg_reg  <= d2_neg;
            s5_mhat_reg <= mhat_next;
            s5_vhat_reg <= vhat_next;
        end
    end

    // root of corrected second moment
    root_tag_t         rt_in, rt_out;
    logic [ROOT_W-1:0] root;

    assign rt_in.valid = s5_valid_reg;
    assign rt_in.neg   = s5_neg_reg;
    assign rt_in.mhat  = s5_mhat_reg;

    adam_sqrt_pipe #(
        .QW (ROOT_W),
        .TW ($bits(root_tag_t))
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .x       (s5_vhat_reg),
        .tag_in  (rt_in),
        .root    (root),
        .tag_out (rt_out)
    );

    // stage 6: denominator and numerator product
    logic            s6_valid_reg;
    logic            s6_neg_reg;
    logic            s6_mzero_reg;
    logic [DD_W-1:0] s6_dd_reg;
    logic [63:0]     s6_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_valid_reg <= rt_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_neg_reg   <= rt_out.neg;
            s6_mzero_reg <= (rt_out.mhat == '0);
            s6_dd_reg    <= DD_W'({root, {ROOT_SHIFT{1'b0}}}) + DD_W'(stability_term_reg);
            s6_prod_reg  <= 64'(learning_rate_reg) * 64'(rt_out.mhat);
        end
    end

    // final division
    final_tag_t           ft_in, ft_out;
    logic [FD_NUM_W-1:0]  num3;
    logic [FD_QUOT_W-1:0] q3;
    logic                 sat3;

    assign ft_in.valid = s6_valid_reg;
    assign ft_in.neg   = s6_neg_reg;
    assign ft_in.mzero = s6_mzero_reg;
    assign num3        = s6_prod_reg + FD_NUM_W'(s6_dd_reg >> 1);

    adam_div_pipe #(
        .NW (FD_NUM_W),
        .DW (DD_W),
        .QB (FD_QUOT_W),
        .TW ($bits(final_tag_t))
    ) u_div_delta (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (num3),
        .den     (s6_dd_reg),
        .tag_in  (ft_in),
        .quot    (q3),
        .sat     (sat3),
        .tag_out (ft_out)
    );

    logic [DATA_W-1:0] cap3, mag, fin;

    assign cap3 = ft_out.neg ? POS_MAX : NEG_MAX;
    assign mag  = ft_out.mzero ? '0 : ((sat3 || (q3 > cap3)) ? cap3 : q3);
    assign fin  = ft_out.neg ? mag : 32'(32'd0 - mag);

    // output register and skid entry
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (delta.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || delta.ready)
        begin
            out_valid_reg <= ft_out.valid;
        end
        else if (ft_out.valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (delta.ready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || delta.ready)
        begin
            out_data_reg <= fin;
        end
        else
        begin
            skid_data_reg <= fin;
        end
    end

    assign delta.valid        = out_valid_reg;
    assign delta.weight_delta = out_data_reg;

endmodule
